// ----- sv/text_to_integer_parser_top_macros.svh -----
// ----------------------------------------------------------------------------
// Text to integer parser assertion macros
// Shared concurrent assertion forms for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_INTEGER_PARSER_TOP_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TTIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TTIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ttip_pkg.sv -----
// ----------------------------------------------------------------------------
// Text to integer parser package
// Parse state, codes and character constants shared by the parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ttip_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_SIGN   = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_UNDER  = 3'd4,
    PH_TRAIL  = 3'd5
  } phase_t;

  // number base
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_HEX = 2'd1,
    RX_OCT = 2'd2,
    RX_BIN = 2'd3
  } radix_t;

  // result status
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_SYNTAX = 2'd1,
    ERR_RANGE  = 2'd2
  } err_t;

  // width mode register codes (3 behaves as 64-bit)
  localparam logic [1:0] WM_16 = 2'd0;
  localparam logic [1:0] WM_32 = 2'd1;
  localparam logic [1:0] WM_64 = 2'd2;

  localparam int unsigned CH_W  = 8;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned WM_W  = 2;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;

  // complete parse state
  typedef struct packed {
    phase_t             phase;
    logic [VAL_W-1:0]   mag;
    logic               neg;
    radix_t             radix;
    logic               seen;
    err_t               err;
  } state_t;

  localparam state_t STATE_RESET = '{
    phase: PH_LEAD,
    mag:   '0,
    neg:   1'b0,
    radix: RX_DEC,
    seen:  1'b0,
    err:   ERR_NONE
  };

endpackage

`default_nettype wire

// ----- sv/ttip_step.sv -----
// ----------------------------------------------------------------------------
// Text to integer parser step
// Next parse state for one character, and the result on the terminating byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_step (
  input  wire ttip_pkg::state_t            st,
  input  wire logic [ttip_pkg::CH_W-1:0]   ch,
  input  wire logic [ttip_pkg::WM_W-1:0]   wm,
  output ttip_pkg::state_t                 nxt,
  output logic [ttip_pkg::VAL_W-1:0]       res_value,
  output ttip_pkg::err_t                   res_status
);

  // digit value in the given base, 16 when not a digit of it
  function automatic logic [4:0] digit_of(input logic [7:0] c, input ttip_pkg::radix_t rx);
    logic [4:0] d;
    logic [4:0] lim;
    d = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h41 + 8'd10);
    end
    unique case (rx)
      ttip_pkg::RX_HEX: lim = 5'd16;
      ttip_pkg::RX_OCT: lim = 5'd8;
      ttip_pkg::RX_BIN: lim = 5'd2;
      default:          lim = 5'd10;
    endcase
    if (d >= lim) begin
      d = 5'd16;
    end
    return d;
  endfunction

  // half of the signed range: 2^(W-1)
  function automatic logic [63:0] half_range(input logic [1:0] w);
    logic [63:0] h;
    unique case (w)
      ttip_pkg::WM_16: h = 64'd1 << 15;
      ttip_pkg::WM_32: h = 64'd1 << 31;
      default:         h = 64'd1 << 63;
    endcase
    return h;
  endfunction

  // largest magnitude that may still be multiplied by the base
  function automatic logic [63:0] mul_limit(input logic [1:0] w, input ttip_pkg::radix_t rx);
    logic [63:0] l;
    unique case (w)
      ttip_pkg::WM_16: begin
        unique case (rx)
          ttip_pkg::RX_HEX: l = 64'd2048;
          ttip_pkg::RX_OCT: l = 64'd4096;
          ttip_pkg::RX_BIN: l = 64'd16384;
          default:          l = 64'd3276;
        endcase
      end
      ttip_pkg::WM_32: begin
        unique case (rx)
          ttip_pkg::RX_HEX: l = 64'd134217728;
          ttip_pkg::RX_OCT: l = 64'd268435456;
          ttip_pkg::RX_BIN: l = 64'd1073741824;
          default:          l = 64'd214748364;
        endcase
      end
      default: begin
        unique case (rx)
          ttip_pkg::RX_HEX: l = 64'd576460752303423488;
          ttip_pkg::RX_OCT: l = 64'd1152921504606846976;
          ttip_pkg::RX_BIN: l = 64'd4611686018427387904;
          default:          l = 64'd922337203685477580;
        endcase
      end
    endcase
    return l;
  endfunction

  logic                 is_sp;
  ttip_pkg::radix_t     rx_use;
  logic [63:0]          mag_use;
  logic                 seen_use;
  logic [4:0]           dig;
  logic                 dig_ok;
  logic                 over;
  logic [63:0]          scaled;
  logic [63:0]          acc;
  ttip_pkg::state_t     step;
  logic                 run;
  logic                 ended_ok;
  logic [63:0]          mag_fin;
  logic [63:0]          half;

  // character class
  assign is_sp = (ch == 8'd32) || (ch >= 8'd9 && ch <= 8'd13);

  // base, magnitude and digit flag as seen by the digit path
  always_comb begin
    unique case (st.phase)
      ttip_pkg::PH_LEAD, ttip_pkg::PH_SIGN, ttip_pkg::PH_ZERO: rx_use = ttip_pkg::RX_DEC;
      default: rx_use = st.radix;
    endcase
    mag_use  = (st.phase == ttip_pkg::PH_ZERO) ? '0 : st.mag;
    seen_use = (st.phase == ttip_pkg::PH_ZERO) ? 1'b1 : st.seen;
  end

  assign dig    = digit_of(ch, rx_use);
  assign dig_ok = ~dig[4];
  assign over   = mag_use > mul_limit(wm, rx_use);

  // multiply by the base with shifts
  always_comb begin
    unique case (rx_use)
      ttip_pkg::RX_HEX: scaled = mag_use << 4;
      ttip_pkg::RX_OCT: scaled = mag_use << 3;
      ttip_pkg::RX_BIN: scaled = mag_use << 1;
      default:          scaled = (mag_use << 3) + (mag_use << 1);
    endcase
  end
  assign acc = scaled + 64'(dig[3:0]);

  // one character of the parse
  always_comb begin
    step = st;
    run  = 1'b0;
    unique case (st.phase)
      ttip_pkg::PH_LEAD: begin
        if (is_sp) begin
          step = st;
        end else if (ch == ttip_pkg::CH_MINUS || ch == ttip_pkg::CH_PLUS) begin
          step.neg   = (ch == ttip_pkg::CH_MINUS);
          step.phase = ttip_pkg::PH_SIGN;
        end else if (ch == ttip_pkg::CH_ZERO) begin
          step.phase = ttip_pkg::PH_ZERO;
        end else begin
          step.radix = ttip_pkg::RX_DEC;
          step.phase = ttip_pkg::PH_DIGITS;
          run        = 1'b1;
        end
      end
      ttip_pkg::PH_SIGN: begin
        if (ch == ttip_pkg::CH_ZERO) begin
          step.phase = ttip_pkg::PH_ZERO;
        end else begin
          step.radix = ttip_pkg::RX_DEC;
          step.phase = ttip_pkg::PH_DIGITS;
          run        = 1'b1;
        end
      end
      ttip_pkg::PH_ZERO: begin
        step.mag   = '0;
        step.phase = ttip_pkg::PH_DIGITS;
        if (ch == 8'h78 || ch == 8'h58) begin
          step.radix = ttip_pkg::RX_HEX;
        end else if (ch == 8'h6F || ch == 8'h4F) begin
          step.radix = ttip_pkg::RX_OCT;
        end else if (ch == 8'h62 || ch == 8'h42) begin
          step.radix = ttip_pkg::RX_BIN;
        end else begin
          step.radix = ttip_pkg::RX_DEC;
          step.seen  = 1'b1;
          run        = 1'b1;
        end
      end
      ttip_pkg::PH_DIGITS, ttip_pkg::PH_UNDER: run = 1'b1;
      ttip_pkg::PH_TRAIL: begin
        if (!is_sp) begin
          step.err = ttip_pkg::ERR_SYNTAX;
        end
      end
      default: step.err = ttip_pkg::ERR_SYNTAX;
    endcase

    // digit, separator and trailing handling
    if (run) begin
      if (dig_ok) begin
        if (over) begin
          step.err = ttip_pkg::ERR_RANGE;
        end else begin
          step.mag   = acc;
          step.seen  = 1'b1;
          step.phase = ttip_pkg::PH_DIGITS;
        end
      end else if (st.phase == ttip_pkg::PH_UNDER) begin
        step.err = ttip_pkg::ERR_SYNTAX;
      end else if (ch == ttip_pkg::CH_UNDER) begin
        if (rx_use == ttip_pkg::RX_DEC && !seen_use) begin
          step.err = ttip_pkg::ERR_SYNTAX;
        end else begin
          step.phase = ttip_pkg::PH_UNDER;
        end
      end else if (!seen_use) begin
        step.err = ttip_pkg::ERR_SYNTAX;
      end else if (is_sp) begin
        step.phase = ttip_pkg::PH_TRAIL;
      end else begin
        step.err = ttip_pkg::ERR_SYNTAX;
      end
    end
  end

  // end of string checks
  assign ended_ok = (st.phase == ttip_pkg::PH_ZERO) ||
                    (st.phase == ttip_pkg::PH_DIGITS && st.seen) ||
                    (st.phase == ttip_pkg::PH_TRAIL);
  assign mag_fin  = (st.phase == ttip_pkg::PH_ZERO) ? '0 : st.mag;
  assign half     = half_range(wm);

  always_comb begin
    res_value  = '0;
    res_status = st.err;
    if (st.err == ttip_pkg::ERR_NONE) begin
      if (!ended_ok) begin
        res_status = ttip_pkg::ERR_SYNTAX;
      end else if (st.neg) begin
        if (mag_fin > half) begin
          res_status = ttip_pkg::ERR_RANGE;
        end else begin
          res_value = '0 - mag_fin;
        end
      end else begin
        if (mag_fin >= half) begin
          res_status = ttip_pkg::ERR_RANGE;
        end else begin
          res_value = mag_fin;
        end
      end
    end
  end

  // next state: clear on terminator, hold once an error is latched
  always_comb begin
    if (ch == ttip_pkg::CH_NUL) begin
      nxt = ttip_pkg::STATE_RESET;
    end else if (st.err != ttip_pkg::ERR_NONE) begin
      nxt = st;
    end else begin
      nxt = step;
    end
  end

endmodule

`default_nettype wire

// ----- sv/text_to_integer_parser_top.sv -----
// A character transaction accepted into the input register is parsed from there
// into the parse state register; the result of a zero byte is loaded into the
// result register in that same step, and out_tvalid rises when the result slot is free.
// Throughput: one character per cycle unless a zero byte waits on a busy result
// slot; the parse step feeding the parse state and result registers is combinational.
// Reset (rst_n low, synchronous): parse state cleared, width_mode back to 64-bit.
// ----------------------------------------------------------------------------
// Text to integer parser top level
// Streams characters in, emits one value and status per zero-terminated string.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_to_integer_parser_top_macros.svh"

module text_to_integer_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // character stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] ch
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,   // [63:0] value, [65:64] status, [71:66] zero
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data  // width_mode
);

  logic                                in_valid_r;
  logic [ttip_pkg::CH_W-1:0]           in_ch_r;
  logic [ttip_pkg::WM_W-1:0]           width_mode_r;
  ttip_pkg::state_t                    state_r;
  ttip_pkg::state_t                    state_nxt;
  logic                                out_valid_r;
  logic [ttip_pkg::VAL_W-1:0]          out_value_r;
  ttip_pkg::err_t                      out_status_r;
  logic [ttip_pkg::VAL_W-1:0]          res_value;
  ttip_pkg::err_t                      res_status;
  logic                                is_term;
  logic                                adv;

  // the registered character moves on unless it needs a busy result slot
  assign is_term   = (in_ch_r == ttip_pkg::CH_NUL);
  assign adv       = in_valid_r && (!is_term || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  ttip_step u_step (
    .st         (state_r),
    .ch         (in_ch_r),
    .wm         (width_mode_r),
    .nxt        (state_nxt),
    .res_value  (res_value),
    .res_status (res_status)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_mode_r <= ttip_pkg::WM_64;
    end else if (cfg_wr_en) begin
      width_mode_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ch_r <= in_tdata;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttip_pkg::STATE_RESET;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && is_term) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_term) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_value_r};

  // checks
  `TTIP_ASSERT_NEXT(a_term_gives_result, adv && is_term, out_valid_r,
    "terminator transaction did not produce a result")
  `TTIP_ASSERT_NEXT(a_no_spurious_result, !out_valid_r && !(adv && is_term), !out_valid_r,
    "result appeared without a terminator")
  `TTIP_ASSERT_NOW(a_err_value_zero, out_valid_r && out_status_r != ttip_pkg::ERR_NONE,
    out_value_r == '0, "error result carries a nonzero value")
  `TTIP_ASSERT_NEXT(a_state_cleared, adv && is_term,
    state_r.phase == ttip_pkg::PH_LEAD && state_r.err == ttip_pkg::ERR_NONE &&
    state_r.mag == '0, "parse state not cleared after terminator")
  `TTIP_ASSERT_NEXT(a_error_sticky, state_r.err != ttip_pkg::ERR_NONE && !(adv && is_term),
    $stable(state_r.err), "latched error changed before terminator")

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Text to integer parser testbench
// Streams zero-terminated strings through the parser: a short directed set,
// then mostly well-formed numbers near the range limits with some corrupted
// strings and raw byte noise. Results are checked against an in-bench parser
// model across all width settings, including a string split over a change.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] WM_SPARE  = 2'd3;   // unused code, behaves as 64-bit
  localparam logic [4:0] NO_DIGIT  = 5'd16;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam int         PHASE_LEN = 210;
  localparam int         N_RANDOM  = 5;

  typedef struct packed {
    logic [63:0]    value;
    ttip_pkg::err_t status;
  } parse_result_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_wr_data = '0;

  // parser model state
  ttip_pkg::phase_t cur_phase;
  logic [63:0]      cur_mag;
  logic             cur_neg;
  ttip_pkg::radix_t cur_radix;
  logic             cur_seen;
  ttip_pkg::err_t   cur_err;
  logic [1:0]       width_sel;

  // character traffic and parsed numbers still to come out
  logic [7:0]    char_q[$];
  logic [7:0]    str_q[$];
  logic [7:0]    carry_q[$];
  parse_result_t parsed_q[$];
  parse_result_t head_result;

  int chars_pushed   = 0;
  int chars_accepted = 0;
  int strings_built  = 0;
  int results_seen   = 0;
  int widths_written = 0;
  int fail_count     = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int stall_cnt      = 0;
  int ready_mode     = 1;
  bit gaps_on        = 1'b1;

  text_to_integer_parser_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [63:0] signed_limit(input logic [1:0] wm);
    case (wm)
      ttip_pkg::WM_16: return 64'd1 << 15;
      ttip_pkg::WM_32: return 64'd1 << 31;
      default:         return 64'd1 << 63;
    endcase
  endfunction

  function automatic logic [63:0] base_of(input ttip_pkg::radix_t rx);
    case (rx)
      ttip_pkg::RX_HEX: return 64'd16;
      ttip_pkg::RX_OCT: return 64'd8;
      ttip_pkg::RX_BIN: return 64'd2;
      default:          return 64'd10;
    endcase
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [4:0] digit_value(input logic [7:0] c, input ttip_pkg::radix_t rx);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= "0" && c <= "9") d = 5'(c - "0");
    else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
    if (d != NO_DIGIT && {59'd0, d} >= base_of(rx)) d = NO_DIGIT;
    return d;
  endfunction

  task automatic reset_parse();
    cur_phase = ttip_pkg::PH_LEAD;
    cur_mag   = '0;
    cur_neg   = 1'b0;
    cur_radix = ttip_pkg::RX_DEC;
    cur_seen  = 1'b0;
    cur_err   = ttip_pkg::ERR_NONE;
  endtask

  // range check happens before the multiply
  task automatic take_digit(input logic [4:0] d);
    logic [63:0] b;
    b = base_of(cur_radix);
    if (cur_mag > signed_limit(width_sel) / b) begin
      cur_err = ttip_pkg::ERR_RANGE;
    end else begin
      cur_mag   = cur_mag * b + {59'd0, d};
      cur_seen  = 1'b1;
      cur_phase = ttip_pkg::PH_DIGITS;
    end
  endtask

  task automatic digit_phase(input logic [7:0] c);
    logic [4:0] d;
    d = digit_value(c, cur_radix);
    if (d != NO_DIGIT) take_digit(d);
    else if (c == ttip_pkg::CH_UNDER) begin
      // underscore may not open a decimal number
      if (cur_radix == ttip_pkg::RX_DEC && !cur_seen) cur_err = ttip_pkg::ERR_SYNTAX;
      else cur_phase = ttip_pkg::PH_UNDER;
    end
    else if (!cur_seen) cur_err = ttip_pkg::ERR_SYNTAX;
    else if (is_blank(c)) cur_phase = ttip_pkg::PH_TRAIL;
    else cur_err = ttip_pkg::ERR_SYNTAX;
  endtask

  task automatic after_sign(input logic [7:0] c);
    if (c == ttip_pkg::CH_ZERO) begin
      cur_phase = ttip_pkg::PH_ZERO;
    end else begin
      cur_radix = ttip_pkg::RX_DEC;
      cur_phase = ttip_pkg::PH_DIGITS;
      digit_phase(c);
    end
  endtask

  task automatic consume_char(input logic [7:0] c);
    logic [4:0] d;
    case (cur_phase)
      ttip_pkg::PH_LEAD: begin
        if (!is_blank(c)) begin
          if (c == ttip_pkg::CH_MINUS || c == ttip_pkg::CH_PLUS) begin
            cur_neg   = (c == ttip_pkg::CH_MINUS);
            cur_phase = ttip_pkg::PH_SIGN;
          end else begin
            after_sign(c);
          end
        end
      end
      ttip_pkg::PH_SIGN: after_sign(c);
      ttip_pkg::PH_ZERO: begin
        // a leading zero either opens a prefix or is a decimal digit
        cur_mag   = '0;
        cur_phase = ttip_pkg::PH_DIGITS;
        if (c == "x" || c == "X") cur_radix = ttip_pkg::RX_HEX;
        else if (c == "o" || c == "O") cur_radix = ttip_pkg::RX_OCT;
        else if (c == "b" || c == "B") cur_radix = ttip_pkg::RX_BIN;
        else begin
          cur_radix = ttip_pkg::RX_DEC;
          cur_seen  = 1'b1;
          digit_phase(c);
        end
      end
      ttip_pkg::PH_DIGITS: digit_phase(c);
      ttip_pkg::PH_UNDER: begin
        d = digit_value(c, cur_radix);
        if (d == NO_DIGIT) cur_err = ttip_pkg::ERR_SYNTAX;
        else take_digit(d);
      end
      ttip_pkg::PH_TRAIL: if (!is_blank(c)) cur_err = ttip_pkg::ERR_SYNTAX;
      default: cur_err = ttip_pkg::ERR_SYNTAX;
    endcase
  endtask

  // one character into the model; a zero byte yields the parsed number
  task automatic advance_parser(input logic [7:0] c);
    parse_result_t res;
    logic          ok;
    if (c != ttip_pkg::CH_NUL) begin
      if (cur_err == ttip_pkg::ERR_NONE) consume_char(c);
    end else begin
      res.value  = '0;
      res.status = cur_err;
      if (cur_err == ttip_pkg::ERR_NONE) begin
        ok = (cur_phase == ttip_pkg::PH_ZERO) ||
             (cur_phase == ttip_pkg::PH_DIGITS && cur_seen) ||
             (cur_phase == ttip_pkg::PH_TRAIL);
        if (cur_phase == ttip_pkg::PH_ZERO) cur_mag = '0;
        if (!ok) res.status = ttip_pkg::ERR_SYNTAX;
        else if (cur_neg) begin
          if (cur_mag > signed_limit(width_sel)) res.status = ttip_pkg::ERR_RANGE;
          else res.value = 64'd0 - cur_mag;
        end
        else if (cur_mag > signed_limit(width_sel) - 64'd1) res.status = ttip_pkg::ERR_RANGE;
        else res.value = cur_mag;
      end
      parsed_q.push_back(res);
      reset_parse();
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    if (d < 4'd10) return 8'h30 + {4'd0, d};
    return (up ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + k[7:0];
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  // render a magnitude most significant digit first, with odd underscores
  task automatic add_digits(input logic [63:0] mag, input ttip_pkg::radix_t rx,
                            input logic up);
    logic [3:0]  dig [0:63];
    logic [63:0] b;
    int          n;
    b = base_of(rx);
    n = 0;
    do begin
      dig[n] = 4'(mag % b);
      mag    = mag / b;
      n++;
    end while (mag != 0);
    for (int i = n - 1; i >= 0; i--) begin
      str_q.push_back(digit_char(dig[i], up));
      if (i != 0 && $urandom_range(0, 5) == 0) str_q.push_back(ttip_pkg::CH_UNDER);
    end
  endtask

  // well-formed number with random layout, biased to the range limits
  task automatic add_number();
    logic [63:0]      lim;
    logic [63:0]      mag;
    ttip_pkg::radix_t rx;
    logic             up;
    int               k;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) str_q.push_back(blank_char());
    k = $urandom_range(0, 3);
    if (k == 0) str_q.push_back(ttip_pkg::CH_MINUS);
    else if (k == 1) str_q.push_back(ttip_pkg::CH_PLUS);
    k  = $urandom_range(0, 19);
    rx = (k < 8) ? ttip_pkg::RX_DEC : (k < 14) ? ttip_pkg::RX_HEX :
         (k < 17) ? ttip_pkg::RX_OCT : ttip_pkg::RX_BIN;
    up = 1'($urandom_range(0, 1));
    if (rx != ttip_pkg::RX_DEC) begin
      str_q.push_back(ttip_pkg::CH_ZERO);
      case (rx)
        ttip_pkg::RX_HEX: str_q.push_back(up ? "X" : "x");
        ttip_pkg::RX_OCT: str_q.push_back(up ? "O" : "o");
        default:          str_q.push_back(up ? "B" : "b");
      endcase
      if ($urandom_range(0, 7) == 0) str_q.push_back(ttip_pkg::CH_UNDER);
    end else if ($urandom_range(0, 7) == 0) begin
      str_q.push_back(ttip_pkg::CH_ZERO);
    end
    lim = signed_limit(width_sel);
    case ($urandom_range(0, 5))
      0:       mag = 64'($urandom_range(0, 999));
      1:       mag = lim - 64'd2 + 64'($urandom_range(0, 3));
      2:       mag = {$urandom, $urandom} & (lim * 2 - 64'd1);
      3:       mag = {$urandom, $urandom};
      4:       mag = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: mag = 64'($urandom_range(0, 15));
    endcase
    add_digits(mag, rx, up);
    // one digit more may push past 64 bits or the selected width
    if ($urandom_range(0, 7) == 0)
      str_q.push_back(digit_char(4'($urandom_range(0, 32'(base_of(rx)) - 1)), up));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) str_q.push_back(blank_char());
  endtask

  task automatic make_random_string();
    int k;
    int p;
    str_q = {};
    k = $urandom_range(0, 9);
    if (k < 7) begin
      add_number();
    end else if (k < 9) begin
      // broken number: replace or insert a byte, or slip in an underscore
      add_number();
      p = $urandom_range(0, str_q.size() - 1);
      case ($urandom_range(0, 2))
        0:       str_q[p] = 8'($urandom_range(1, 255));
        1:       str_q.insert(p, 8'($urandom_range(1, 255)));
        default: str_q.insert(p, ttip_pkg::CH_UNDER);
      endcase
    end else begin
      repeat ($urandom_range(0, 6)) str_q.push_back(8'($urandom_range(1, 255)));
    end
  endtask

  // terminate the string; a split string finishes in the next phase
  task automatic finish_string(input bit split);
    int k;
    str_q.push_back(ttip_pkg::CH_NUL);
    k = str_q.size();
    if (split && str_q.size() > 1) k = $urandom_range(1, str_q.size() - 1);
    for (int i = 0; i < str_q.size(); i++) begin
      if (i < k) begin
        char_q.push_back(str_q[i]);
        chars_pushed++;
      end else begin
        carry_q.push_back(str_q[i]);
      end
    end
    str_q = {};
    strings_built++;
  endtask

  task automatic write_width(input logic [1:0] w);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    width_sel = w;
    widths_written++;
  endtask

  // every character taken, every number out, then the parse pipeline settles
  task automatic wait_drained();
    do @(posedge clk);
    while (chars_accepted != chars_pushed || parsed_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [1:0] widths [0:N_RANDOM-1];
    bit         done;
    widths = '{ttip_pkg::WM_32, WM_SPARE, ttip_pkg::WM_16, ttip_pkg::WM_64,
               ttip_pkg::WM_32};
    width_sel = ttip_pkg::WM_64;
    reset_parse();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed strings at full width
    write_width(ttip_pkg::WM_64);
    add_text("0");       finish_string(1'b0);  // lone zero
    finish_string(1'b0);                       // empty string
    add_text("-0x");     finish_string(1'b0);  // prefix without digits
    add_text("\t+0b_1"); finish_string(1'b0);  // blank, sign, underscore after prefix
    str_q.push_back(8'hFF);
    add_text("9");       finish_string(1'b0);  // top byte, rest ignored after error
    wait_drained();

    // narrowest negative limit
    write_width(ttip_pkg::WM_16);
    add_text("-0x8000"); finish_string(1'b0);
    wait_drained();

    // random phases, each but the last leaving a string open across the width change
    for (int ph = 0; ph < N_RANDOM; ph++) begin
      write_width(widths[ph]);
      gaps_on    = (ph != 1);
      ready_mode = ph % 4;
      foreach (carry_q[i]) begin
        char_q.push_back(carry_q[i]);
        chars_pushed++;
      end
      carry_q = {};
      done = 1'b0;
      while (!done) begin
        make_random_string();
        done = char_q.size() + str_q.size() + 1 >= PHASE_LEN;
        finish_string(done && ph != N_RANDOM - 1);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("run covered %0d characters in %0d strings, %0d numbers checked",
             chars_accepted, strings_built, results_seen);
    $display("width register written %0d times, all four codes used", widths_written);
    if (fail_count == 0) begin
      $display("text_to_integer_parser_top: match");
    end else begin
      $display("text_to_integer_parser_top: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("text_to_integer_parser_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  // character source in bursts, model advanced on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        chars_accepted++;
        advance_parser(in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (char_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= char_q.pop_front();
          if (gaps_on) begin
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 16);
              gap_left   = $urandom_range(1, 8);
            end else begin
              burst_left--;
            end
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  // result sink with its own stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (parsed_q.size() == 0) begin
          $error("result transaction with no number pending");
          fail_count++;
        end else begin
          head_result = parsed_q.pop_front();
          if (out_tdata[63:0] !== head_result.value) begin
            $error("value: expected %0d, actual %0d",
                   $signed(head_result.value), $signed(out_tdata[63:0]));
            fail_count++;
          end
          if (out_tdata[65:64] !== head_result.status) begin
            $error("status: expected %0d, actual %0d", head_result.status,
                   out_tdata[65:64]);
            fail_count++;
          end
          if (out_tdata[71:66] !== 6'd0) begin
            $error("pad: expected 0, actual %0d", out_tdata[71:66]);
            fail_count++;
          end
        end
      end
      stall_cnt++;
      case (ready_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= (stall_cnt % 4) == 0;
        default: out_tready <= (stall_cnt % 16) == 0;
      endcase
    end
  end

endmodule
